// ----- sv/bounded_double_ended_queue_defines.svh -----
// assertion macros for the bounded double-ended queue checker
// depends on nothing; included by the checker file
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define BDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bdq_pkg.sv -----
// shared constants, request codes and controller command struct
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    localparam int WORD_W    = 32;
    localparam int REQ_W     = 3;
    localparam int CAP_W     = 7;
    localparam int DEPTH_DEF = 64;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd64;
    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd4;

    typedef struct packed {
        logic exec;     // request transfer: update pointers, count, storage
        logic capture;  // register storage reads at front and rear
        logic load;     // fill the result register
    } dp_cmd_t;

endpackage

`default_nettype wire

// ----- sv/bdq_if.sv -----
// valid/ready channel interfaces for requests, results and configuration
// depends on bdq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bdq_req_if;
    import bdq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink (input valid, input req_type, input value, output ready);
endinterface

interface bdq_rsp_if;
    import bdq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink (input valid, input ok, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

interface bdq_cfg_if;
    import bdq_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// ----- sv/bounded_double_ended_queue.sv -----
// a request transfer updates pointers, count and storage; a registered two-port
//   read then captures the new front and rear entries, and the result register is
//   loaded from them once the previous result is drained; requests are not overlapped
// a new request is taken while the previous result still waits in the output register
// reset: pointers and count cleared, capacity 64; storage holds no reset value
`timescale 1ns / 1ps
`default_nettype none

module bounded_double_ended_queue #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bdq_req_if.sink    req,
    bdq_rsp_if.source  rsp,
    bdq_cfg_if.sink    cfg
);
    import bdq_pkg::*;

    dp_cmd_t cmd;

    // configuration is always taken
    assign cfg.ready = 1'b1;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg.valid),
        .cfg_capacity    (cfg.capacity),
        .in_req_type     (req.req_type),
        .in_value        (req.value),
        .out_ok          (rsp.ok),
        .out_front_value (rsp.front_value),
        .out_rear_value  (rsp.rear_value),
        .out_is_empty    (rsp.is_empty),
        .out_is_full     (rsp.is_full)
    );

endmodule

`default_nettype wire

// ----- sv/bdq_ctrl.sv -----
// sequencing state machine: accept, storage read, result load
// depends on bdq_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output bdq_pkg::dp_cmd_t cmd
);
    import bdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load_ok;

    // result register is free when empty or being drained this cycle
    assign load_ok     = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign cmd.exec    = in_valid && (state_reg == S_IDLE);
    assign cmd.capture = (state_reg == S_READ);
    assign cmd.load    = (state_reg == S_LOAD) && load_ok;

    // a load in the same cycle as a drain keeps the result valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    if (load_ok)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/bdq_datapath.sv -----
// ring storage, head/tail pointers, entry count, capacity and result register
// depends on bdq_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdq_datapath #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire bdq_pkg::dp_cmd_t                 cmd,
    input  wire logic                             cfg_we,
    input  wire logic [bdq_pkg::CAP_W-1:0]        cfg_capacity,
    input  wire logic [bdq_pkg::REQ_W-1:0]        in_req_type,
    input  wire logic signed [bdq_pkg::WORD_W-1:0] in_value,
    output logic                                  out_ok,
    output logic signed [bdq_pkg::WORD_W-1:0]     out_front_value,
    output logic signed [bdq_pkg::WORD_W-1:0]     out_rear_value,
    output logic                                  out_is_empty,
    output logic                                  out_is_full
);
    import bdq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIM_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [CAP_W-1:0]  cap_reg;
    logic [PTR_W-1:0]  front_reg, front_next;
    logic [PTR_W-1:0]  rear_reg, rear_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ok_reg, ok_next;
    logic [WORD_W-1:0] rd_front_reg;
    logic [WORD_W-1:0] rd_rear_reg;

    logic              res_ok_reg;
    logic [WORD_W-1:0] res_front_reg;
    logic [WORD_W-1:0] res_rear_reg;
    logic              res_empty_reg;
    logic              res_full_reg;

    logic [LIM_W-1:0] cap_ext;
    logic [LIM_W-1:0] limit;
    logic             full;
    logic             empty;
    logic             is_push;
    logic             is_pop;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] front_prev;
    logic [PTR_W-1:0] front_succ;
    logic [PTR_W-1:0] rear_prev;
    logic [PTR_W-1:0] rear_succ;

    // zero capacity acts as one, anything above the ring size as the ring size
    assign cap_ext = LIM_W'(cap_reg);
    always_comb
    begin
        priority if (cap_reg == '0)
            limit = LIM_W'(1);
        else if (cap_ext > LIM_W'(DEPTH))
            limit = LIM_W'(DEPTH);
        else
            limit = cap_ext;
    end

    assign full  = LIM_W'(count_reg) >= limit;
    assign empty = (count_reg == '0);

    assign front_prev = (front_reg == '0) ? PTR_LAST : front_reg - PTR_W'(1);
    assign front_succ = (front_reg == PTR_LAST) ? '0 : front_reg + PTR_W'(1);
    assign rear_prev  = (rear_reg == '0) ? PTR_LAST : rear_reg - PTR_W'(1);
    assign rear_succ  = (rear_reg == PTR_LAST) ? '0 : rear_reg + PTR_W'(1);

    assign is_push = (in_req_type == REQ_PUSH_FRONT) || (in_req_type == REQ_PUSH_BACK);
    assign is_pop  = (in_req_type == REQ_POP_FRONT) || (in_req_type == REQ_POP_BACK);
    assign wr_en   = cmd.exec && is_push && !full;

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        ok_next    = 1'b1;
        wr_addr    = front_reg;
        if (is_push)
        begin
            if (full)
            begin
                ok_next = 1'b0;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                // first entry lands at the front slot and both ends meet there
                if (empty)
                begin
                    rear_next = front_reg;
                    wr_addr   = front_reg;
                end
                else if (in_req_type == REQ_PUSH_FRONT)
                begin
                    front_next = front_prev;
                    wr_addr    = front_prev;
                end
                else
                begin
                    rear_next = rear_succ;
                    wr_addr   = rear_succ;
                end
            end
        end
        else if (is_pop)
        begin
            if (empty)
            begin
                ok_next = 1'b0;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
                // last entry out leaves both pointers in place
                if (count_reg != CNT_W'(1))
                begin
                    if (in_req_type == REQ_POP_FRONT)
                        front_next = front_succ;
                    else
                        rear_next = rear_prev;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            front_reg <= '0;
            rear_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_capacity;
            end
            if (cmd.exec)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_value;
        end
        if (cmd.capture)
        begin
            rd_front_reg <= mem[front_reg];
            rd_rear_reg  <= mem[rear_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ok_reg <= ok_next;
        end
        if (cmd.load)
        begin
            res_ok_reg    <= ok_reg;
            res_front_reg <= empty ? EMPTY_WORD : rd_front_reg;
            res_rear_reg  <= empty ? EMPTY_WORD : rd_rear_reg;
            res_empty_reg <= empty;
            res_full_reg  <= full;
        end
    end

    assign out_ok          = res_ok_reg;
    assign out_front_value = res_front_reg;
    assign out_rear_value  = res_rear_reg;
    assign out_is_empty    = res_empty_reg;
    assign out_is_full     = res_full_reg;

endmodule

`default_nettype wire

// ----- sv/bdq_checker.sv -----
// port-level assertions for the bounded double-ended queue, bound to the top level
// depends on bdq_pkg and bounded_double_ended_queue_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_double_ended_queue_defines.svh"

module bdq_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             req_valid,
    input wire logic                             req_ready,
    input wire logic                             rsp_valid,
    input wire logic                             rsp_ready,
    input wire logic                             rsp_ok,
    input wire logic signed [bdq_pkg::WORD_W-1:0] rsp_front_value,
    input wire logic signed [bdq_pkg::WORD_W-1:0] rsp_rear_value,
    input wire logic                             rsp_is_empty,
    input wire logic                             rsp_is_full
);
    import bdq_pkg::*;

    // a stalled result keeps all of its fields
    `BDQ_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ok) && $stable(rsp_front_value) && $stable(rsp_rear_value) && $stable(rsp_is_empty) && $stable(rsp_is_full), "result changed while stalled")

    // an empty queue reports all-ones at both ends
    `BDQ_ASSERT_IMP(a_empty_word, clk, rst_n, rsp_valid && rsp_is_empty, (rsp_front_value == EMPTY_WORD) && (rsp_rear_value == EMPTY_WORD), "empty result without all-ones words")

    // capacity is at least one, so empty and full never meet
    `BDQ_ASSERT_IMP(a_empty_full, clk, rst_n, rsp_valid, !(rsp_is_empty && rsp_is_full), "result both empty and full")

    // one request at a time: busy right after a request transfer
    `BDQ_ASSERT_NXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while busy")

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_ok          (rsp.ok),
    .rsp_front_value (rsp.front_value),
    .rsp_rear_value  (rsp.rear_value),
    .rsp_is_empty    (rsp.is_empty),
    .rsp_is_full     (rsp.is_full)
);

`default_nettype wire
